// ===== sv/spq_pkg.sv =====
package spq_pkg;

    // Default number of entry slots
    localparam int SPQ_DEPTH_DEFAULT = 16;

    // Fixed field widths
    localparam int VALUE_W     = 32;
    localparam int PRIO_W      = 16;
    localparam int COUNT_OUT_W = 5;
    localparam int IN_DATA_W   = VALUE_W + PRIO_W;
    localparam int OUT_DATA_W  = VALUE_W + 3 * PRIO_W + COUNT_OUT_W + 3 - PRIO_W;

    // Operation codes carried on the input tuser
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_POP    = 1'b1;

    // One stored queue entry
    typedef struct packed {
        logic [PRIO_W-1:0]  prio;
        logic [VALUE_W-1:0] value;
    } entry_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_item;
        logic ins_step;
        logic ins_place;
        logic pop_adv;
        logic head_load;
        logic err_set;
        logic out_load;
    } spq_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic op_pop;
        logic q_full;
        logic q_empty;
        logic cnt_one;
        logic idx_zero;
        logic idx_one;
        logic rd_lower;
        logic out_free;
    } spq_status_t;

endpackage

// ===== sv/spq_ram.sv =====
module spq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/spq_datapath.sv =====
module spq_datapath
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = SPQ_DEPTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  spq_cmd_t              cmd,
    output spq_status_t           status,
    input  logic [IN_DATA_W-1:0]  in_data,
    input  logic                  in_func,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

    // Step a circular slot pointer back or forward
    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == '0) ? LAST_SLOT : p - PTR_W'(1);
        return r;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == LAST_SLOT) ? '0 : p + PTR_W'(1);
        return r;
    endfunction

    // Control state
    logic [PTR_W-1:0] head_ptr_reg, head_ptr_next;
    logic [PTR_W-1:0] tail_ptr_reg, tail_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    // Payload state
    logic             op_reg;
    entry_t           item_reg;
    logic [PTR_W-1:0] hole_reg;
    logic [CNT_W-1:0] idx_reg;
    entry_t           head_reg;
    entry_t           popped_reg;
    logic             err_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    // Memory ports
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    entry_t           wr_data;
    logic [PTR_W-1:0] rd_addr;
    entry_t           rd_data;
    logic [$bits(entry_t)-1:0] rd_bits;

    logic [PRIO_W-1:0] head_prio_out;

    spq_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_bits)
    );

    assign rd_data = rd_bits;

    // Shift an entry up into the hole, or drop the new item into it
    always_comb
    begin
        wr_en   = cmd.ins_step | cmd.ins_place;
        wr_addr = hole_reg;
        wr_data = cmd.ins_step ? rd_data : item_reg;
    end

    // Look one slot below the hole, two while stepping, or at the next head on pop
    always_comb
    begin
        priority if (cmd.ins_step)
        begin
            rd_addr = ptr_dec(ptr_dec(hole_reg));
        end
        else if (cmd.pop_adv)
        begin
            rd_addr = ptr_inc(head_ptr_reg);
        end
        else
        begin
            rd_addr = ptr_dec(hole_reg);
        end
    end

    // Next values of control state
    always_comb
    begin
        head_ptr_next  = head_ptr_reg;
        tail_ptr_next  = tail_ptr_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (cmd.ins_place)
        begin
            tail_ptr_next = ptr_inc(tail_ptr_reg);
            cnt_next      = cnt_reg + CNT_W'(1);
        end
        if (cmd.pop_adv)
        begin
            head_ptr_next = ptr_inc(head_ptr_reg);
            cnt_next      = cnt_reg - CNT_W'(1);
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_ptr_reg  <= '0;
            tail_ptr_reg  <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_ptr_reg  <= head_ptr_next;
            tail_ptr_reg  <= tail_ptr_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign head_prio_out = (cnt_reg == '0) ? '0 : head_reg.prio;

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg     <= in_func;
            item_reg   <= in_data;
            hole_reg   <= tail_ptr_reg;
            idx_reg    <= cnt_reg;
            popped_reg <= '0;
            err_reg    <= 1'b0;
        end
        if (cmd.ins_step)
        begin
            hole_reg <= ptr_dec(hole_reg);
            idx_reg  <= idx_reg - CNT_W'(1);
        end
        if (cmd.ins_place && idx_reg == '0)
        begin
            head_reg <= item_reg;
        end
        if (cmd.pop_adv)
        begin
            popped_reg <= head_reg;
        end
        if (cmd.head_load)
        begin
            head_reg <= rd_data;
        end
        if (cmd.err_set)
        begin
            err_reg <= 1'b1;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= {err_reg,
                             cnt_reg == FULL_CNT,
                             cnt_reg == '0,
                             COUNT_OUT_W'(cnt_reg),
                             head_prio_out,
                             popped_reg.prio,
                             popped_reg.value};
        end
    end

    // Status back to the controller
    always_comb
    begin
        status.op_pop   = (op_reg == FUNC_POP);
        status.q_full   = (cnt_reg == FULL_CNT);
        status.q_empty  = (cnt_reg == '0);
        status.cnt_one  = (cnt_reg == CNT_W'(1));
        status.idx_zero = (idx_reg == '0);
        status.idx_one  = (idx_reg == CNT_W'(1));
        status.rd_lower = (rd_data.prio < item_reg.prio);
        status.out_free = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Occupancy never exceeds the slot count
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FULL_CNT)
        else $error("occupancy above queue depth");

    // A pop only advances a non-empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_adv |-> cnt_reg != '0)
        else $error("pop advanced an empty queue");

    // The insert walk never steps past the head
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins_step |-> (idx_reg != '0 && !status.q_full))
        else $error("insert walk stepped past the head");

    // A placed entry raises the count by exactly one
    a_place_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins_place |=> cnt_reg == $past(cnt_reg) + CNT_W'(1))
        else $error("insert did not raise the count by one");

endmodule

// ===== sv/spq_ctrl.sv =====
module spq_ctrl
    import spq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  spq_status_t status,
    output spq_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_INS_CMP,
        ST_INS_PLACE,
        ST_POP_LOAD,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    // Sequence one item at a time
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (status.op_pop)
                begin
                    if (status.q_empty)
                    begin
                        cmd.err_set = 1'b1;
                        state_next  = ST_FINISH;
                    end
                    else
                    begin
                        cmd.pop_adv = 1'b1;
                        state_next  = status.cnt_one ? ST_FINISH : ST_POP_LOAD;
                    end
                end
                else
                begin
                    if (status.q_full)
                    begin
                        cmd.err_set = 1'b1;
                        state_next  = ST_FINISH;
                    end
                    else if (status.idx_zero)
                    begin
                        cmd.ins_place = 1'b1;
                        state_next    = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_INS_CMP;
                    end
                end
            end
            ST_INS_CMP:
            begin
                if (status.rd_lower)
                begin
                    cmd.ins_step = 1'b1;
                    state_next   = status.idx_one ? ST_INS_PLACE : ST_INS_CMP;
                end
                else
                begin
                    cmd.ins_place = 1'b1;
                    state_next    = ST_FINISH;
                end
            end
            ST_INS_PLACE:
            begin
                cmd.ins_place = 1'b1;
                state_next    = ST_FINISH;
            end
            ST_POP_LOAD:
            begin
                cmd.head_load = 1'b1;
                state_next    = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A result is only loaded into a free output register
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result loaded over an untaken result");

endmodule

// ===== sv/sorted_priority_queue_unit.sv =====
// Sorted max-priority queue with QUEUE_DEPTH entry slots.
// Input stream (s_axis): one operation per transfer. tuser selects insert
// (0) or pop (1); tdata carries the value and priority of an insert.
// Output stream (m_axis): exactly one result per operation, in order: the
// popped value and priority (zero unless a pop succeeded), the head priority,
// the count, empty and full flags after the operation, and an error flag for
// a pop on an empty queue or an insert on a full one (both ignored).
// Equal priorities leave in arrival order.
// Entries live in a single-port-pair RAM used as a ring; an insert walks
// from the tail toward the head, moving each lower-priority entry up one slot
// per cycle. An insert into an empty queue places the item without a walk; a
// pop reads the new head from the RAM unless it empties the queue. One
// operation is in progress at a time.
// Reset empties the queue at once; no clearing pass is needed.
// The result sits in an output register; if m_axis stalls, the block still
// accepts and works the next operation and holds its result until the
// output register is taken.
module sorted_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = SPQ_DEPTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // item_value[31:0], item_priority[47:32]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // func[0]
    input  logic [0:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // popped_value[31:0], popped_priority[47:32], head_priority[63:48],
    // entry_count[68:64], is_empty[69], is_full[70], op_error[71]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    spq_cmd_t    cmd;
    spq_status_t status;

    spq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    spq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_axis_tdata),
        .in_func   (s_axis_tuser[0]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule
